// ===== rtl/core/tdce_pkg.sv =====
// Shared types and constants of the TDC hit delta encoder.
// Used by tdce_cfg, tdce_encode, the top level and its checker.
package tdce_pkg;

	localparam int unsigned TIME_W  = 20;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 1;

	localparam logic [SYM_W-1:0]   ESCAPE_SYMBOL = 8'd128;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hffff;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_TRAILING = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_RESERVED = 1'b1;

	// Input item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_HIT   = 1'b1;

	// Lengths of the three time-difference forms, prefix included, and of the start and whole-word codes
	localparam logic [LEN_W-1:0] LEN_SHORT = 6'd7;
	localparam logic [LEN_W-1:0] LEN_MID   = 6'd12;
	localparam logic [LEN_W-1:0] LEN_LONG  = 6'd22;
	localparam logic [LEN_W-1:0] LEN_START = 6'd2;
	localparam logic [LEN_W-1:0] LEN_WORD  = 6'd32;

	typedef struct packed {
		logic strip_trailing;
		logic strip_reserved_bit;
	} cfg_t;

	typedef struct packed {
		logic               has_symbol;
		logic [SYM_W-1:0]   symbol;
		logic [WORD_W-1:0]  code_bits;
		logic [LEN_W-1:0]   code_length;
		logic [COUNT_W-1:0] kept_count;
	} result_t;

	typedef struct packed {
		logic               emit;
		logic               set_time;
		logic [TIME_W-1:0]  next_time;
		logic [COUNT_W-1:0] next_count;
	} update_t;

endpackage

// ===== rtl/core/tdc_hit_delta_encoder.sv =====
// TDC hit delta encoder: takes one item (start of block or 32-bit hit word) per
// cycle and gives at most one coded result, from an input register through the
// single-pass coder into a result register. Throughput is
// one item per clock as long as the result side does not stall; a held result
// stalls the input side in the same cycle. Dropped trailing-edge hits give no
// transfer on the result side. Depends on tdce_pkg, tdce_cfg and tdce_encode.
module tdc_hit_delta_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tdce_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tdce_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [tdce_pkg::WORD_W-1:0]        hit_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                has_symbol,
	output logic [tdce_pkg::SYM_W-1:0]         symbol,
	output logic [tdce_pkg::WORD_W-1:0]        code_bits,
	output logic [tdce_pkg::LEN_W-1:0]         code_length,
	output logic [tdce_pkg::COUNT_W-1:0]       kept_count
);

	tdce_pkg::cfg_t                cfg;
	tdce_pkg::result_t             res;
	tdce_pkg::update_t             upd;

	logic                          valid_s1;
	logic                          kind_s1;
	logic [tdce_pkg::WORD_W-1:0]  word_s1;
	logic                          valid_s2;
	tdce_pkg::result_t             res_s2;
	logic [tdce_pkg::TIME_W-1:0]  last_time_q;
	logic [tdce_pkg::COUNT_W-1:0] hit_count_q;
	logic                          s2_free, advance;

	tdce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tdce_encode u_encode (
		.kind      (kind_s1),
		.word      (word_s1),
		.cfg       (cfg),
		.last_time (last_time_q),
		.hit_count (hit_count_q),
		.res       (res),
		.upd       (upd)
	);

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1 <= kind;
			word_s1 <= hit_word;
		end
	end

	// Coder state, advanced when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			hit_count_q <= '0;
		end else if (advance) begin
			hit_count_q <= upd.next_count;
			if (upd.set_time) begin
				last_time_q <= upd.next_time;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance && upd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && upd.emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign has_symbol  = res_s2.has_symbol;
	assign symbol      = res_s2.symbol;
	assign code_bits   = res_s2.code_bits;
	assign code_length = res_s2.code_length;
	assign kept_count  = res_s2.kept_count;

endmodule

// ===== rtl/core/tdce_cfg.sv =====
// Configuration registers of the TDC hit delta encoder.
// Depends on tdce_pkg.
module tdce_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tdce_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tdce_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tdce_pkg::cfg_t                      cfg
);

	tdce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_trailing     <= 1'b1;
			cfg_q.strip_reserved_bit <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tdce_pkg::CFG_STRIP_TRAILING: cfg_q.strip_trailing     <= cfg_data[0];
				tdce_pkg::CFG_STRIP_RESERVED: cfg_q.strip_reserved_bit <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tdce_encode.sv =====
// Single-pass coder: turns one registered item into a result and the next state.
// Depends on tdce_pkg.
module tdce_encode (
	input  logic                              kind,
	input  logic [tdce_pkg::WORD_W-1:0]      word,
	input  tdce_pkg::cfg_t                    cfg,
	input  logic [tdce_pkg::TIME_W-1:0]      last_time,
	input  logic [tdce_pkg::COUNT_W-1:0]     hit_count,
	output tdce_pkg::result_t                 res,
	output tdce_pkg::update_t                 upd
);

	logic                          r1, start, edge_bit;
	logic [6:0]                    channel;
	logic [1:0]                    r2;
	logic [tdce_pkg::TIME_W-1:0]  t;
	logic [tdce_pkg::TIME_W:0]    diff;
	logic                          fits_short, fits_mid, escape, drop;
	logic [1:0]                    head_bits;
	logic [tdce_pkg::LEN_W-1:0]   head_len;
	logic [tdce_pkg::COUNT_W-1:0] count_inc;

	assign r1       = word[31];
	assign channel  = word[30:24];
	assign start    = word[23];
	assign r2       = word[22:21];
	assign edge_bit = word[20];
	assign t        = word[19:0];

	// Signed difference, one bit wider than the time field
	assign diff = {1'b0, t} - {1'b0, last_time};
	assign fits_short = (diff[20:5] == '0) || (diff[20:5] == '1);
	assign fits_mid   = (diff[20:9] == '0) || (diff[20:9] == '1);

	assign escape = (r2 != 2'b00) || start;
	assign drop   = cfg.strip_trailing && !edge_bit;

	assign count_inc = (hit_count == tdce_pkg::COUNT_MAX) ? hit_count : hit_count + 1'b1;

	// Optional r1 and edge bits, right aligned
	always_comb begin
		head_bits = 2'b00;
		head_len  = '0;
		if (!cfg.strip_reserved_bit && !cfg.strip_trailing) begin
			head_bits = {r1, edge_bit};
			head_len  = 6'd2;
		end else if (!cfg.strip_reserved_bit) begin
			head_bits = {1'b0, r1};
			head_len  = 6'd1;
		end else if (!cfg.strip_trailing) begin
			head_bits = {1'b0, edge_bit};
			head_len  = 6'd1;
		end
	end

	always_comb begin
		res = '0;
		upd.emit       = 1'b1;
		upd.set_time   = 1'b0;
		upd.next_time  = last_time;
		upd.next_count = hit_count;
		if (kind == tdce_pkg::KIND_START) begin
			res.code_bits   = {30'd0, cfg.strip_trailing, cfg.strip_reserved_bit};
			res.code_length = tdce_pkg::LEN_START;
			upd.set_time    = 1'b1;
			upd.next_time   = '0;
			upd.next_count  = '0;
		end else if (escape) begin
			res.has_symbol  = 1'b1;
			res.symbol      = tdce_pkg::ESCAPE_SYMBOL;
			res.code_bits   = word;
			res.code_length = tdce_pkg::LEN_WORD;
			res.kept_count  = count_inc;
			upd.next_count  = count_inc;
		end else if (drop) begin
			upd.emit = 1'b0;
		end else begin
			res.has_symbol = 1'b1;
			res.symbol     = {1'b0, channel};
			res.kept_count = count_inc;
			if (fits_short) begin
				res.code_bits   = {23'd0, head_bits, 1'b0, diff[5:0]};
				res.code_length = head_len + tdce_pkg::LEN_SHORT;
			end else if (fits_mid) begin
				res.code_bits   = {18'd0, head_bits, 2'b10, diff[9:0]};
				res.code_length = head_len + tdce_pkg::LEN_MID;
			end else begin
				res.code_bits   = {8'd0, head_bits, 2'b11, diff[19:0]};
				res.code_length = head_len + tdce_pkg::LEN_LONG;
			end
			upd.set_time   = 1'b1;
			upd.next_time  = t;
			upd.next_count = count_inc;
		end
	end

endmodule

// ===== rtl/core/tdce_checker.sv =====
// Port-level checks of the TDC hit delta encoder, bound to the top level.
// Depends on tdce_pkg.
module tdce_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                has_symbol,
	input logic [tdce_pkg::SYM_W-1:0]         symbol,
	input logic [tdce_pkg::LEN_W-1:0]         code_length,
	input logic [tdce_pkg::COUNT_W-1:0]       kept_count
);

	// Input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(code_length) && $stable(symbol)))
		else $error("held result changed");

	// Start-of-block results carry only the two flags and a cleared count
	a_start_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_symbol) |->
			(code_length == tdce_pkg::LEN_START && kept_count == '0))
		else $error("bad start-of-block result");

	// Escaped words travel whole, and count as kept
	a_escape_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_symbol && symbol == tdce_pkg::ESCAPE_SYMBOL) |->
			(code_length == tdce_pkg::LEN_WORD && kept_count != '0))
		else $error("bad escape result");

endmodule

bind tdc_hit_delta_encoder tdce_checker u_tdce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.has_symbol  (has_symbol),
	.symbol      (symbol),
	.code_length (code_length),
	.kept_count  (kept_count)
);

// ===== tb/sv/tdce_result_checker.sv =====
// Result checker for the TDC hit delta encoder: watches config writes and both
// channels, predicts each coded result and compares it. Depends on tdce_pkg.
`timescale 1ns / 100ps

module tdce_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tdce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tdce_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             kind,
	input  logic [tdce_pkg::WORD_W-1:0]      hit_word,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             has_symbol,
	input  logic [tdce_pkg::SYM_W-1:0]       symbol,
	input  logic [tdce_pkg::WORD_W-1:0]      code_bits,
	input  logic [tdce_pkg::LEN_W-1:0]       code_length,
	input  logic [tdce_pkg::COUNT_W-1:0]     kept_count,
	output int                               failures,
	output int                               pending
);

	typedef struct packed {
		logic                        r1;
		logic [6:0]                  channel;
		logic                        start;
		logic [1:0]                  r2;
		logic                        leading;
		logic [tdce_pkg::TIME_W-1:0] stamp;
	} tdc_word_t;

	logic                         strip_trailing = 1'b1;
	logic                         strip_reserved = 1'b1;
	logic [tdce_pkg::TIME_W-1:0]  last_stamp = '0;
	logic [tdce_pkg::COUNT_W-1:0] kept_hits = '0;
	tdce_pkg::result_t            expected_codes[$];
	int                           mismatch_count = 0;
	int                           queued = 0;

	assign failures = mismatch_count;
	assign pending  = queued;

	task automatic encode_item(input logic item_kind, input tdc_word_t word);
		tdce_pkg::result_t res;
		int                delta;
		res.has_symbol  = 1'b1;
		res.symbol      = tdce_pkg::ESCAPE_SYMBOL;
		res.code_bits   = word;
		res.code_length = tdce_pkg::LEN_WORD;
		res.kept_count  = '0;
		if (item_kind == tdce_pkg::KIND_START) begin
			last_stamp      = '0;
			kept_hits       = '0;
			res.has_symbol  = 1'b0;
			res.symbol      = '0;
			res.code_bits   = {30'b0, strip_trailing, strip_reserved};
			res.code_length = tdce_pkg::LEN_START;
			expected_codes.push_back(res);
		end else if (word.start || word.r2 != 2'b00) begin
			// escaped word: time base untouched, still counts as kept
			if (kept_hits != tdce_pkg::COUNT_MAX)
				kept_hits++;
			res.kept_count = kept_hits;
			expected_codes.push_back(res);
		end else if (!(strip_trailing && !word.leading)) begin
			res.symbol      = {1'b0, word.channel};
			res.code_bits   = '0;
			res.code_length = '0;
			if (!strip_reserved) begin
				res.code_bits   = {res.code_bits[tdce_pkg::WORD_W-2:0], word.r1};
				res.code_length = res.code_length + 6'd1;
			end
			if (!strip_trailing) begin
				res.code_bits   = {res.code_bits[tdce_pkg::WORD_W-2:0], word.leading};
				res.code_length = res.code_length + 6'd1;
			end
			delta = int'(word.stamp) - int'(last_stamp);
			if (delta >= -32 && delta < 32) begin
				res.code_bits = (res.code_bits << tdce_pkg::LEN_SHORT) | {26'b0, delta[5:0]};
				res.code_length = res.code_length + tdce_pkg::LEN_SHORT;
			end else if (delta >= -512 && delta < 512) begin
				res.code_bits = (res.code_bits << tdce_pkg::LEN_MID) |
					{20'b0, 2'b10, delta[9:0]};
				res.code_length = res.code_length + tdce_pkg::LEN_MID;
			end else begin
				res.code_bits = (res.code_bits << tdce_pkg::LEN_LONG) |
					{10'b0, 2'b11, delta[19:0]};
				res.code_length = res.code_length + tdce_pkg::LEN_LONG;
			end
			last_stamp = word.stamp;
			if (kept_hits != tdce_pkg::COUNT_MAX)
				kept_hits++;
			res.kept_count = kept_hits;
			expected_codes.push_back(res);
		end
	endtask

	task automatic check_result();
		tdce_pkg::result_t seen;
		tdce_pkg::result_t want;
		seen.has_symbol  = has_symbol;
		seen.symbol      = symbol;
		seen.code_bits   = code_bits;
		seen.code_length = code_length;
		seen.kept_count  = kept_count;
		if (expected_codes.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: unexpected result has=%0b sym=%0d bits=%h len=%0d cnt=%0d",
					$realtime, seen.has_symbol, seen.symbol, seen.code_bits,
					seen.code_length, seen.kept_count);
		end else begin
			want = expected_codes.pop_front();
			if (seen.has_symbol !== want.has_symbol || seen.symbol !== want.symbol ||
			    seen.code_bits !== want.code_bits || seen.code_length !== want.code_length ||
			    seen.kept_count !== want.kept_count) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: expected has=%0b sym=%0d bits=%h len=%0d cnt=%0d",
						$realtime, want.has_symbol, want.symbol, want.code_bits,
						want.code_length, want.kept_count);
					$display("%0t:   actual has=%0b sym=%0d bits=%h len=%0d cnt=%0d",
						$realtime, seen.has_symbol, seen.symbol, seen.code_bits,
						seen.code_length, seen.kept_count);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_trailing = 1'b1;
			strip_reserved = 1'b1;
			last_stamp     = '0;
			kept_hits      = '0;
		end else begin
			// results leave before this edge's transfer can add a new expectation
			if (out_valid && !out_stall)
				check_result();
			if (cfg_write) begin
				if (cfg_index == tdce_pkg::CFG_STRIP_TRAILING)
					strip_trailing = cfg_data[0];
				else if (cfg_index == tdce_pkg::CFG_STRIP_RESERVED)
					strip_reserved = cfg_data[0];
			end
			if (in_valid && !in_stall)
				encode_item(kind, hit_word);
			queued = expected_codes.size();
		end
	end

endmodule

// ===== tb/sv/tb_tdc_hit_delta_encoder.sv =====
// Top of the TDC hit delta encoder testbench: clock, reset, config writes, hit
// stimulus with random idling and receiver stalls. Depends on tdce_pkg and tdce_result_checker.
`timescale 1ns / 100ps

module tb_tdc_hit_delta_encoder;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 175;
	localparam int STAMP_W      = tdce_pkg::TIME_W;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [tdce_pkg::CFG_INDEX_W-1:0] cfg_index = tdce_pkg::CFG_STRIP_TRAILING;
	logic [tdce_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             kind = tdce_pkg::KIND_START;
	logic [tdce_pkg::WORD_W-1:0]      hit_word = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             has_symbol;
	logic [tdce_pkg::SYM_W-1:0]       symbol;
	logic [tdce_pkg::WORD_W-1:0]      code_bits;
	logic [tdce_pkg::LEN_W-1:0]       code_length;
	logic [tdce_pkg::COUNT_W-1:0]     kept_count;
	int                               failures;
	int                               pending;
	int                               cycle_count = 0;
	logic                             send_gaps = 1'b0;
	logic                             recv_stalls = 1'b0;
	logic                             strip_now = 1'b1;
	logic [STAMP_W-1:0]               base_stamp = '0;

	tdc_hit_delta_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .hit_word(hit_word),
		.out_valid(out_valid), .out_stall(out_stall), .has_symbol(has_symbol),
		.symbol(symbol), .code_bits(code_bits), .code_length(code_length),
		.kept_count(kept_count)
	);

	tdce_result_checker code_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .hit_word(hit_word),
		.out_valid(out_valid), .out_stall(out_stall), .has_symbol(has_symbol),
		.symbol(symbol), .code_bits(code_bits), .code_length(code_length),
		.kept_count(kept_count), .failures(failures), .pending(pending)
	);

	always #1 clk = ~clk;

	// receiver backpressure in bursts
	always begin
		@(posedge clk);
		if (recv_stalls && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 19)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_tdc_hit_delta_encoder: errors");
		$finish;
	end

	function automatic logic [tdce_pkg::WORD_W-1:0] pack_hit(input logic r1,
	                                                        input logic [6:0] channel,
	                                                        input logic leading,
	                                                        input logic [STAMP_W-1:0] t);
		return {r1, channel, 1'b0, 2'b00, leading, t};
	endfunction

	function automatic logic [STAMP_W-1:0] pick_delta();
		int bounds [8] = '{-33, 32, -32, 31, -513, 512, -512, 511};
		case ($urandom_range(0, 4))
			0: return STAMP_W'($urandom_range(0, 63) - 32);
			1: return STAMP_W'($urandom_range(0, 1023) - 512);
			2: return STAMP_W'(bounds[$urandom_range(0, 7)]);
			3: return STAMP_W'($urandom_range(0, 2047) - 1024);
			default: return STAMP_W'($urandom);
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the transfer happened
	task automatic send_item(input logic item_kind, input logic [tdce_pkg::WORD_W-1:0] word);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= item_kind;
		hit_word <= word;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	// wait out all results, then the pipeline depth for dropped hits
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic trailing, input logic reserved);
		cfg_write <= 1'b1;
		cfg_index <= tdce_pkg::CFG_STRIP_TRAILING;
		cfg_data  <= trailing;
		@(posedge clk);
		cfg_index <= tdce_pkg::CFG_STRIP_RESERVED;
		cfg_data  <= reserved;
		@(posedge clk);
		cfg_write <= 1'b0;
		strip_now = trailing;
	endtask

	task automatic open_block();
		send_item(tdce_pkg::KIND_START, $urandom);
		base_stamp = '0;
	endtask

	task automatic run_random(input int count, input logic quiet);
		logic [tdce_pkg::WORD_W-1:0] word;
		logic [STAMP_W-1:0]          t;
		logic                        leading;
		int                          pick;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				send_gaps   = !quiet && $urandom_range(0, 2) != 0;
				recv_stalls = !quiet && $urandom_range(0, 2) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				open_block();
			end else if (pick < 12) begin
				send_item(tdce_pkg::KIND_HIT, $urandom);
			end else if (pick < 24) begin
				word = $urandom;
				if ($urandom_range(0, 1))
					word[23] = 1'b1;
				else
					word[22:21] = 2'($urandom_range(1, 3));
				send_item(tdce_pkg::KIND_HIT, word);
			end else begin
				t = base_stamp + pick_delta();
				leading = $urandom_range(0, 4) != 0;
				send_item(tdce_pkg::KIND_HIT,
					pack_hit(1'($urandom), 7'($urandom), leading, t));
				if (leading || !strip_now)
					base_stamp = t;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: delta form boundaries, escapes, dropped trailing edge
		write_config(1'b1, 1'b1);
		open_block();
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd0, 1'b1, 20'd0));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd127, 1'b1, 20'd31));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd5, 1'b1, 20'd63));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd64, 1'b1, 20'd31));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd1, 1'b1, 20'd542));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd2, 1'b1, 20'd30));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd3, 1'b1, 20'd542));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd4, 1'b1, 20'd29));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd126, 1'b1, 20'hfffff));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd7, 1'b1, 20'd0));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd9, 1'b0, 20'd100));
		send_item(tdce_pkg::KIND_HIT, {1'b0, 7'd10, 1'b1, 2'b00, 1'b1, 20'd5});
		send_item(tdce_pkg::KIND_HIT, {1'b1, 7'd11, 1'b0, 2'b10, 1'b0, 20'd7});
		send_item(tdce_pkg::KIND_HIT, 32'hffff_ffff);
		drain();
		write_config(1'b0, 1'b0);
		open_block();
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b1, 7'd0, 1'b0, 20'd3));
		send_item(tdce_pkg::KIND_HIT, pack_hit(1'b0, 7'd127, 1'b1, 20'd0));
		drain();

		run_random(PHASE_ITEMS, 1'b0);
		drain();
		write_config(1'b1, 1'b0);
		open_block();
		run_random(PHASE_ITEMS, 1'b0);
		drain();

		// keep trailing edges, strip the reserved bit
		write_config(1'b0, 1'b1);
		open_block();
		run_random(PHASE_ITEMS, 1'b0);
		drain();

		write_config(1'b1, 1'b1);
		open_block();
		run_random(PHASE_ITEMS, 1'b1);
		drain();

		if (failures == 0)
			$display("tb_tdc_hit_delta_encoder: clean");
		else
			$display("tb_tdc_hit_delta_encoder: errors");
		$finish;
	end

endmodule
